>>> design/uvsct_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the sphere tessellator.
`timescale 1ns / 1ps
package uvsct_pkg;

    // quarter-wave table: 2**SINE_LOG2 entries, a full turn is 4 * SINE_ENTRIES phase units
    localparam int SINE_LOG2    = 10;
    localparam int SINE_ENTRIES = 1 << SINE_LOG2;
    localparam int PHASE_W      = SINE_LOG2 + 2;
    localparam int SINE_W       = 15;
    localparam int Q14_ONE      = 16384;

    localparam int COUNT_W = 11;
    localparam int IDX_W   = 10;
    localparam int DATA_W  = 16;
    localparam int TEX_W   = 17;
    localparam int TEX_ONE = 65536;

    // index * 65536 / count, bit-serial, six quotient bits per cycle
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = COUNT_W + FRAC_W;
    localparam int DIV_STEPS  = 6;
    localparam int DIV_CYCLES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_W      = DIV_CYCLES * DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_CYCLES + 1);
    localparam int LANES      = 4;

    // phase = round(quotient / 2**shift)
    localparam int POLAR_SHIFT = FRAC_W - (SINE_LOG2 + 1);
    localparam int AZIM_SHIFT  = FRAC_W - (SINE_LOG2 + 2);

    localparam logic [2:0] SLOT_LAST = 3'd5;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [2:0] {
        REG_STACK_COUNT   = 3'd0,
        REG_SLICE_COUNT   = 3'd1,
        REG_SPHERE_RADIUS = 3'd2,
        REG_CENTER_X      = 3'd3,
        REG_CENTER_Y      = 3'd4,
        REG_CENTER_Z      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       stacks;   // zero already mapped to one
        logic [COUNT_W-1:0]       slices;
        logic [DATA_W-1:0]        radius;
        logic signed [DATA_W-1:0] center_x;
        logic signed [DATA_W-1:0] center_y;
        logic signed [DATA_W-1:0] center_z;
    } cfg_t;

    typedef struct packed {
        logic [QUO_W-1:0]   quo;
        logic [COUNT_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        div_res_t row0;
        div_res_t row1;
        div_res_t col0;
        div_res_t col1;
    } cell_res_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic [2:0]       slot;
        logic             last;
    } vtx_tag_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] norm_x;
        logic signed [DATA_W-1:0] norm_y;
        logic signed [DATA_W-1:0] norm_z;
        vtx_tag_t                 tag;
    } vertex_t;

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // sin(k*pi/(2N)) in Q1.14 from a Q2.30 odd Taylor series, terms up to x^17
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        logic [63:0]       theta;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            theta = (64'(k) * PI_Q30 * 64'd2 + 64'd2 * 64'(SINE_ENTRIES)) >> (SINE_LOG2 + 2);
            x2    = (theta * theta) >> 30;
            term  = theta;
            sum   = $signed(theta);
            term  = ((term * x2) >> 30) / 64'd6;
            sum   = sum - $signed(term);
            term  = ((term * x2) >> 30) / 64'd20;
            sum   = sum + $signed(term);
            term  = ((term * x2) >> 30) / 64'd42;
            sum   = sum - $signed(term);
            term  = ((term * x2) >> 30) / 64'd72;
            sum   = sum + $signed(term);
            term  = ((term * x2) >> 30) / 64'd110;
            sum   = sum - $signed(term);
            term  = ((term * x2) >> 30) / 64'd156;
            sum   = sum + $signed(term);
            term  = ((term * x2) >> 30) / 64'd210;
            sum   = sum - $signed(term);
            term  = ((term * x2) >> 30) / 64'd272;
            sum   = sum + $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            rom[k] = SINE_W'((sum + 64'sd32768) >>> 16);
        end
        return rom;
    endfunction

endpackage

>>> design/uvsct_front.sv
// Front end: takes a cell and runs four bit-serial dividers for the corner row/column ratios.
`timescale 1ns / 1ps
module uvsct_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uvsct_pkg::cfg_t               cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uvsct_pkg::IDX_W-1:0]   cell_row,
    input  logic [uvsct_pkg::IDX_W-1:0]   cell_col,
    output logic                          res_valid,
    input  logic                          res_ready,
    output uvsct_pkg::cell_res_t          res_data
);

    localparam int NW = uvsct_pkg::NUM_W;
    localparam int CW = uvsct_pkg::COUNT_W;

    logic                           busy_reg;
    logic [uvsct_pkg::CNT_W-1:0]    cnt_reg;
    logic [NW-1:0]                  num_reg  [uvsct_pkg::LANES];
    logic [CW-1:0]                  rem_reg  [uvsct_pkg::LANES];
    logic [NW-1:0]                  num_next [uvsct_pkg::LANES];
    logic [CW-1:0]                  rem_next [uvsct_pkg::LANES];
    logic [CW-1:0]                  lane_idx [uvsct_pkg::LANES];
    logic [CW-1:0]                  lane_div [uvsct_pkg::LANES];
    logic                           done;
    logic                           accept;

    assign done      = busy_reg && (cnt_reg == uvsct_pkg::CNT_W'(uvsct_pkg::DIV_CYCLES));
    assign s_tready  = !busy_reg || (done && res_ready);
    assign accept    = s_tvalid && s_tready;
    assign res_valid = done;

    assign lane_idx[0] = {1'b0, cell_row};
    assign lane_idx[1] = {1'b0, cell_row} + CW'(1);
    assign lane_idx[2] = {1'b0, cell_col};
    assign lane_idx[3] = {1'b0, cell_col} + CW'(1);
    assign lane_div[0] = cfg.stacks;
    assign lane_div[1] = cfg.stacks;
    assign lane_div[2] = cfg.slices;
    assign lane_div[3] = cfg.slices;

    // restoring division, DIV_STEPS quotient bits per cycle, remainder stays below divisor
    always_comb begin
        logic [CW-1:0] r;
        logic [NW-1:0] n;
        logic [CW:0]   t;
        logic          qbit;
        for (int l = 0; l < uvsct_pkg::LANES; l++) begin
            r = rem_reg[l];
            n = num_reg[l];
            for (int s = 0; s < uvsct_pkg::DIV_STEPS; s++) begin
                t    = {r, n[NW-1]};
                qbit = (t >= {1'b0, lane_div[l]});
                if (qbit) begin
                    r = CW'(t - {1'b0, lane_div[l]});
                end else begin
                    r = t[CW-1:0];
                end
                n = {n[NW-2:0], qbit};
            end
            rem_next[l] = r;
            num_next[l] = n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (done) begin
            if (res_ready) begin
                busy_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + uvsct_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < uvsct_pkg::LANES; l++) begin
            if (accept) begin
                num_reg[l] <= NW'({lane_idx[l], uvsct_pkg::FRAC_W'(0)});
                rem_reg[l] <= '0;
            end else if (busy_reg && !done) begin
                num_reg[l] <= num_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    assign res_data.row0.quo = num_reg[0][uvsct_pkg::QUO_W-1:0];
    assign res_data.row0.rem = rem_reg[0];
    assign res_data.row1.quo = num_reg[1][uvsct_pkg::QUO_W-1:0];
    assign res_data.row1.rem = rem_reg[1];
    assign res_data.col0.quo = num_reg[2][uvsct_pkg::QUO_W-1:0];
    assign res_data.col0.rem = rem_reg[2];
    assign res_data.col1.quo = num_reg[3][uvsct_pkg::QUO_W-1:0];
    assign res_data.col1.rem = rem_reg[3];

endmodule

>>> design/uvsct_queue.sv
// Two-entry queue of divided cells between the front end and the vertex pipeline.
`timescale 1ns / 1ps
module uvsct_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  uvsct_pkg::cell_res_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uvsct_pkg::cell_res_t out_data
);

    uvsct_pkg::cell_res_t mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> design/uvsct_back.sv
// Back end: walks a cell's six vertex slots and computes position, normal and texture per vertex.
`timescale 1ns / 1ps
module uvsct_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uvsct_pkg::cfg_t      cfg,
    input  logic                 cell_valid,
    output logic                 cell_pop,
    input  uvsct_pkg::cell_res_t cell_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output uvsct_pkg::vertex_t   m_vertex
);

    localparam int L  = uvsct_pkg::SINE_LOG2;
    localparam int PW = uvsct_pkg::PHASE_W;
    localparam int SW = uvsct_pkg::SINE_W;
    localparam int DW = uvsct_pkg::DATA_W;
    localparam int QW = uvsct_pkg::QUO_W;

    localparam uvsct_pkg::sine_rom_t POLAR_ROM = uvsct_pkg::build_sine_rom();
    localparam uvsct_pkg::sine_rom_t AZIM_ROM  = uvsct_pkg::build_sine_rom();

    typedef struct packed {
        logic [L-1:0] addr;
        logic         neg;
        logic         one;
    } sine_addr_t;

    // corner for each slot: A = c0 c2 c1, B = c1 c2 c3; bit0 = column step, bit1 = row step
    function automatic logic [1:0] corner_of(input logic [2:0] slot);
        logic [1:0] c;
        unique case (slot)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd2;
            3'd2:    c = 2'd1;
            3'd3:    c = 2'd1;
            3'd4:    c = 2'd2;
            default: c = 2'd3;
        endcase
        return c;
    endfunction

    // quadrant folding; cosine is the sine a quarter turn later
    function automatic sine_addr_t sine_lookup(input logic [PW-1:0] ph, input logic cosine);
        sine_addr_t   a;
        logic [1:0]   quad;
        logic [L-1:0] r;
        quad  = ph[PW-1 -: 2] + {1'b0, cosine};
        r     = ph[L-1:0];
        a.neg = quad[1];
        if (quad[0]) begin
            a.one  = (r == '0);
            a.addr = L'(0) - r;
        end else begin
            a.one  = 1'b0;
            a.addr = r;
        end
        return a;
    endfunction

    function automatic logic signed [DW-1:0] sine_value(input logic [SW-1:0] raw,
                                                        input logic neg, input logic one);
        logic [DW-1:0] mag;
        mag = one ? DW'(uvsct_pkg::Q14_ONE) : {1'b0, raw};
        return neg ? $signed(DW'(0) - mag) : $signed(mag);
    endfunction

    logic en;
    logic [2:0] slot_reg;
    logic       fire0;

    // stage 1: phases and texture
    logic                 v1_reg;
    logic [PW-1:0]        pp1_reg;
    logic [PW-1:0]        pa1_reg;
    uvsct_pkg::vtx_tag_t  tag1_reg;
    // stage 2: table read
    logic                 v2_reg;
    logic [SW-1:0]        sp_raw_reg, cp_raw_reg, sa_raw_reg, ca_raw_reg;
    sine_addr_t           sp_a_reg, cp_a_reg, sa_a_reg, ca_a_reg;
    uvsct_pkg::vtx_tag_t  tag2_reg;
    // stage 3: signed trig
    logic                     v3_reg;
    logic signed [DW-1:0]     sp3_reg, cp3_reg, sa3_reg, ca3_reg;
    uvsct_pkg::vtx_tag_t      tag3_reg;
    // stage 4: products
    logic                     v4_reg;
    logic signed [31:0]       px4_reg, pz4_reg;
    logic signed [DW-1:0]     ny4_reg;
    uvsct_pkg::vtx_tag_t      tag4_reg;
    // stage 5: normals
    logic                     v5_reg;
    logic signed [DW-1:0]     nx5_reg, ny5_reg, nz5_reg;
    uvsct_pkg::vtx_tag_t      tag5_reg;
    // stage 6: radius products
    logic                     v6_reg;
    logic signed [32:0]       rx6_reg, ry6_reg, rz6_reg;
    logic signed [DW-1:0]     nx6_reg, ny6_reg, nz6_reg;
    uvsct_pkg::vtx_tag_t      tag6_reg;
    // output register
    logic                     out_valid_reg;
    uvsct_pkg::vertex_t       out_reg;

    assign en       = !out_valid_reg || m_tready;
    assign fire0    = en && cell_valid;
    assign cell_pop = fire0 && (slot_reg == uvsct_pkg::SLOT_LAST);
    assign m_tvalid = out_valid_reg;
    assign m_vertex = out_reg;

    // ---- stage 0: corner select, rounding of the quotients
    logic [1:0]           corner;
    uvsct_pkg::div_res_t  jr, ir;
    logic [QW:0]          tu_full, tv_full, pa_sum, pp_sum;
    logic [PW-1:0]        pa0, pp0;
    logic [uvsct_pkg::TEX_W-1:0] tu0, tv0;

    always_comb begin
        corner  = corner_of(slot_reg);
        jr      = corner[1] ? cell_data.row1 : cell_data.row0;
        ir      = corner[0] ? cell_data.col1 : cell_data.col0;
        tu_full = {1'b0, jr.quo}
                + (QW+1)'({jr.rem, 1'b0} >= {1'b0, cfg.stacks});
        tv_full = {1'b0, ir.quo}
                + (QW+1)'({ir.rem, 1'b0} >= {1'b0, cfg.slices});
        tu0 = (tu_full > (QW+1)'(uvsct_pkg::TEX_ONE)) ? uvsct_pkg::TEX_W'(uvsct_pkg::TEX_ONE)
                                                     : tu_full[uvsct_pkg::TEX_W-1:0];
        tv0 = (tv_full > (QW+1)'(uvsct_pkg::TEX_ONE)) ? uvsct_pkg::TEX_W'(uvsct_pkg::TEX_ONE)
                                                     : tv_full[uvsct_pkg::TEX_W-1:0];
        pa_sum = {1'b0, jr.quo} + (QW+1)'(1 << (uvsct_pkg::AZIM_SHIFT - 1));
        pp_sum = {1'b0, ir.quo} + (QW+1)'(1 << (uvsct_pkg::POLAR_SHIFT - 1));
        pa0    = pa_sum[uvsct_pkg::AZIM_SHIFT +: PW];
        pp0    = pp_sum[uvsct_pkg::POLAR_SHIFT +: PW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 3'd0;
        end else if (fire0) begin
            slot_reg <= (slot_reg == uvsct_pkg::SLOT_LAST) ? 3'd0 : slot_reg + 3'd1;
        end
    end

    // ---- stage 1: table addresses
    sine_addr_t sp_a, cp_a, sa_a, ca_a;
    assign sp_a = sine_lookup(pp1_reg, 1'b0);
    assign cp_a = sine_lookup(pp1_reg, 1'b1);
    assign sa_a = sine_lookup(pa1_reg, 1'b0);
    assign ca_a = sine_lookup(pa1_reg, 1'b1);

    // ---- stage 4/6 rounding and position
    logic signed [31:0]   px_sum, pz_sum;
    logic signed [32:0]   rx_sum, ry_sum, rz_sum;
    logic signed [19:0]   dx, dy, dz;

    function automatic logic signed [DW-1:0] sat16(input logic signed [19:0] v);
        logic signed [DW-1:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        px_sum = px4_reg + 32'sd8192;
        pz_sum = pz4_reg + 32'sd8192;
        rx_sum = rx6_reg + 33'sd8192;
        ry_sum = ry6_reg + 33'sd8192;
        rz_sum = rz6_reg + 33'sd8192;
        dx = 20'($signed(rx_sum[32:14])) - 20'(cfg.center_x);
        dy = 20'($signed(ry_sum[32:14])) - 20'(cfg.center_y);
        dz = 20'($signed(rz_sum[32:14])) - 20'(cfg.center_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= cell_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp1_reg        <= pp0;
            pa1_reg        <= pa0;
            tag1_reg.tex_u <= tu0;
            tag1_reg.tex_v <= tv0;
            tag1_reg.slot  <= slot_reg;
            tag1_reg.last  <= (slot_reg == uvsct_pkg::SLOT_LAST);

            sp_raw_reg <= POLAR_ROM[sp_a.addr];
            cp_raw_reg <= POLAR_ROM[cp_a.addr];
            sa_raw_reg <= AZIM_ROM[sa_a.addr];
            ca_raw_reg <= AZIM_ROM[ca_a.addr];
            sp_a_reg   <= sp_a;
            cp_a_reg   <= cp_a;
            sa_a_reg   <= sa_a;
            ca_a_reg   <= ca_a;
            tag2_reg   <= tag1_reg;

            sp3_reg  <= sine_value(sp_raw_reg, sp_a_reg.neg, sp_a_reg.one);
            cp3_reg  <= sine_value(cp_raw_reg, cp_a_reg.neg, cp_a_reg.one);
            sa3_reg  <= sine_value(sa_raw_reg, sa_a_reg.neg, sa_a_reg.one);
            ca3_reg  <= sine_value(ca_raw_reg, ca_a_reg.neg, ca_a_reg.one);
            tag3_reg <= tag2_reg;

            px4_reg  <= sp3_reg * ca3_reg;
            pz4_reg  <= sp3_reg * sa3_reg;
            ny4_reg  <= cp3_reg;
            tag4_reg <= tag3_reg;

            nx5_reg  <= px_sum[29:14];
            nz5_reg  <= pz_sum[29:14];
            ny5_reg  <= ny4_reg;
            tag5_reg <= tag4_reg;

            rx6_reg  <= $signed({1'b0, cfg.radius}) * nx5_reg;
            ry6_reg  <= $signed({1'b0, cfg.radius}) * ny5_reg;
            rz6_reg  <= $signed({1'b0, cfg.radius}) * nz5_reg;
            nx6_reg  <= nx5_reg;
            ny6_reg  <= ny5_reg;
            nz6_reg  <= nz5_reg;
            tag6_reg <= tag5_reg;

            out_reg.pos_x  <= sat16(dx);
            out_reg.pos_y  <= sat16(dy);
            out_reg.pos_z  <= sat16(dz);
            out_reg.norm_x <= nx6_reg;
            out_reg.norm_y <= ny6_reg;
            out_reg.norm_z <= nz6_reg;
            out_reg.tag    <= tag6_reg;
        end
    end

endmodule

>>> design/uv_sphere_cell_tessellator.sv
// UV sphere cell tessellator: one grid cell in, six vertices (two triangles) out, one per item.
// The front end divides the four corner indices by the stack and slice counts with bit-serial
// dividers that deliver six quotient bits per cycle, and it takes a new cell only when idle or
// while handing over the previous result; the back end then emits one vertex per cycle while
// the output is not stalled and a cell is queued, six per cell, through six pipeline stages
// (quarter-wave sine ROM read, two multiply stages, rounding and saturation) followed by an
// output register. A two-entry queue sits between the two halves. Configuration writes are
// taken at any time and must only be issued while no cell is in flight.
`timescale 1ns / 1ps
module uv_sphere_cell_tessellator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // cell_row[9:0], cell_col[19:10], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (16 each),
                                    // tex_u[112:96], tex_v[129:113], vertex_slot[132:130], pad
    output logic         m_tlast    // last_vertex
);

    localparam int CW = uvsct_pkg::COUNT_W;
    localparam int DW = uvsct_pkg::DATA_W;

    logic [CW-1:0]        stack_count_reg;
    logic [CW-1:0]        slice_count_reg;
    logic [DW-1:0]        sphere_radius_reg;
    logic signed [DW-1:0] center_x_reg;
    logic signed [DW-1:0] center_y_reg;
    logic signed [DW-1:0] center_z_reg;

    uvsct_pkg::cfg_t      cfg;
    uvsct_pkg::cell_res_t front_data, queue_data;
    uvsct_pkg::vertex_t   vtx;
    logic                 front_valid, front_ready;
    logic                 queue_valid, queue_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg   <= CW'(16);
            slice_count_reg   <= CW'(16);
            sphere_radius_reg <= DW'(256);
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (uvsct_pkg::cfg_reg_t'(cfg_index))
                uvsct_pkg::REG_STACK_COUNT:   stack_count_reg   <= cfg_data[CW-1:0];
                uvsct_pkg::REG_SLICE_COUNT:   slice_count_reg   <= cfg_data[CW-1:0];
                uvsct_pkg::REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                uvsct_pkg::REG_CENTER_X:      center_x_reg      <= $signed(cfg_data);
                uvsct_pkg::REG_CENTER_Y:      center_y_reg      <= $signed(cfg_data);
                uvsct_pkg::REG_CENTER_Z:      center_z_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // a zero count behaves as one
    assign cfg.stacks   = (stack_count_reg == '0) ? CW'(1) : stack_count_reg;
    assign cfg.slices   = (slice_count_reg == '0) ? CW'(1) : slice_count_reg;
    assign cfg.radius   = sphere_radius_reg;
    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.center_z = center_z_reg;

    uvsct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cell_row  (s_tdata[9:0]),
        .cell_col  (s_tdata[19:10]),
        .res_valid (front_valid),
        .res_ready (front_ready),
        .res_data  (front_data)
    );

    uvsct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (queue_valid),
        .out_ready (queue_pop),
        .out_data  (queue_data)
    );

    uvsct_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cell_valid (queue_valid),
        .cell_pop   (queue_pop),
        .cell_data  (queue_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_vertex   (vtx)
    );

    assign m_tdata = {3'b000, vtx.tag.slot, vtx.tag.tex_v, vtx.tag.tex_u,
                      vtx.norm_z, vtx.norm_y, vtx.norm_x,
                      vtx.pos_z, vtx.pos_y, vtx.pos_x};
    assign m_tlast = vtx.tag.last;

endmodule
